FILE: src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

   // Fraction bits of saturation and brightness (1.0 = 1 << FRAC_BITS)
   localparam int FRAC_BITS     = 12;
   // Fraction bits of the hue angle in degrees
   localparam int HUE_FRAC_BITS = 6;

   localparam int HUE_W  = HUE_FRAC_BITS + 9;
   localparam int SV_W   = FRAC_BITS + 1;
   localparam int SECTOR_W = 60 << HUE_FRAC_BITS;
   localparam int D_W    = $clog2(SECTOR_W + 1);
   localparam int T_W    = $clog2(2 * SECTOR_W);
   localparam int CH_W   = 2 * FRAC_BITS + 1;
   localparam int NUM_W  = 2 * FRAC_BITS + $clog2(SECTOR_W + 1);
   // 255 / SECTOR_W reduces to 17 / 2^(HUE_FRAC_BITS + 2)
   localparam int SCL_W  = NUM_W + 5;
   localparam int SHIFT  = 2 * FRAC_BITS + HUE_FRAC_BITS + 2;
   localparam int MAX_K  = ((1 << HUE_W) - 1) / SECTOR_W;
   localparam int K_W    = $clog2(MAX_K + 1);

   // Sector codes: which channel gets chroma, x and zero
   localparam logic [2:0] SEC_CX0 = 3'd0;
   localparam logic [2:0] SEC_XC0 = 3'd1;
   localparam logic [2:0] SEC_0CX = 3'd2;
   localparam logic [2:0] SEC_0XC = 3'd3;
   localparam logic [2:0] SEC_X0C = 3'd4;
   localparam logic [2:0] SEC_C0X = 3'd5;

   // Classified item passed from front to back
   typedef struct packed {
      logic [2:0]      sector;
      logic [D_W-1:0]  delta;
      logic [SV_W-1:0] sat;
      logic [SV_W-1:0] bri;
   } item_type;

endpackage

FILE: src/hsv2rgb_front.sv
module hsv2rgb_front import hsv2rgb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [HUE_W-1:0]  in_hue,
   input  logic [SV_W-1:0]   in_sat,
   input  logic [SV_W-1:0]   in_bri,
   output logic              out_valid,
   input  logic              out_ready,
   output item_type          out_item
);

   localparam logic [SV_W-1:0] ONE = SV_W'(1 << FRAC_BITS);

   logic       valid_ff, valid_in;
   item_type   item_ff, item_in;
   logic [K_W-1:0]   k;
   logic [K_W-1:0]   k_even;
   logic [T_W-1:0]   t;
   logic [HUE_W-1:0] base;

   // Raw sector index: highest multiple of the sector width not above hue
   always_comb begin
      k = '0;
      for (int j = 1; j <= MAX_K; j++) begin
         if (in_hue >= HUE_W'(j * SECTOR_W)) k = K_W'(j);
      end
   end

   // Position inside the 120-degree period and distance from its middle
   always_comb begin
      k_even = {k[K_W-1:1], 1'b0};
      base   = HUE_W'(k_even * SECTOR_W);
      t      = T_W'(in_hue - base);
      item_in.delta  = (t >= T_W'(SECTOR_W)) ? D_W'(t - T_W'(SECTOR_W))
                                             : D_W'(T_W'(SECTOR_W) - t);
      item_in.sector = (k > K_W'(5)) ? SEC_C0X : k[2:0];
      item_in.sat    = (in_sat > ONE) ? ONE : in_sat;
      item_in.bri    = (in_bri > ONE) ? ONE : in_bri;
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: src/hsv2rgb_queue.sv
module hsv2rgb_queue import hsv2rgb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = mem[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/hsv2rgb_back.sv
module hsv2rgb_back import hsv2rgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_red,
   output logic [7:0]  out_green,
   output logic [7:0]  out_blue
);

   localparam logic [SCL_W-1:0] HALF = SCL_W'(1) << (SHIFT - 1);

   // Scale a numerator by 255 / (2^(2F) * W), round half up, saturate
   function automatic logic [7:0] to_byte(input logic [NUM_W-1:0] num);
      logic [SCL_W-1:0] scaled;
      logic [SCL_W-1:0] q;
      scaled = (SCL_W'(num) << 4) + SCL_W'(num) + HALF;
      q      = scaled >> SHIFT;
      to_byte = (q > SCL_W'(255)) ? 8'd255 : q[7:0];
   endfunction

   logic adv;

   // Stage 1: chroma
   logic                v1_ff;
   logic [2:0]          sec1_ff;
   logic [D_W-1:0]      d1_ff;
   logic [SV_W-1:0]     v_1_ff;
   logic [CH_W-1:0]     chr1_ff, chr1_in;
   logic [2*SV_W-1:0]   vs_prod;

   // Stage 2: chroma times distance
   logic                v2_ff;
   logic [2:0]          sec2_ff;
   logic [CH_W-1:0]     vfull2_ff, vfull2_in;
   logic [CH_W-1:0]     chr2_ff;
   logic [NUM_W-1:0]    prod2_ff, prod2_in;
   logic [CH_W+D_W-1:0] cd_prod;

   // Stage 3: channel numerators
   logic                v3_ff;
   logic [2:0]          sec3_ff;
   logic [NUM_W-1:0]    numc3_ff, numc3_in;
   logic [NUM_W-1:0]    numz3_ff, numz3_in;
   logic [NUM_W-1:0]    numx3_ff, numx3_in;

   // Output register
   logic                vo_ff;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;
   logic [7:0]          blue_ff, blue_in;
   logic [7:0]          c_byte, z_byte, x_byte;

   // Whole back pipeline moves when the output slot is free or taken
   assign adv      = !vo_ff || out_ready;
   assign in_ready = adv;

   assign vs_prod  = in_item.bri * in_item.sat;
   assign chr1_in  = vs_prod[CH_W-1:0];

   assign cd_prod   = chr1_ff * d1_ff;
   assign prod2_in  = cd_prod[NUM_W-1:0];
   assign vfull2_in = CH_W'(v_1_ff) << FRAC_BITS;

   assign numc3_in = NUM_W'(vfull2_ff) * NUM_W'(SECTOR_W);
   assign numz3_in = NUM_W'(vfull2_ff - chr2_ff) * NUM_W'(SECTOR_W);
   assign numx3_in = numc3_in - prod2_ff;

   // Channel bytes and sector mapping
   always_comb begin
      c_byte = to_byte(numc3_ff);
      z_byte = to_byte(numz3_ff);
      x_byte = to_byte(numx3_ff);
      case (sec3_ff)
         SEC_CX0: begin red_in = c_byte; green_in = x_byte; blue_in = z_byte; end
         SEC_XC0: begin red_in = x_byte; green_in = c_byte; blue_in = z_byte; end
         SEC_0CX: begin red_in = z_byte; green_in = c_byte; blue_in = x_byte; end
         SEC_0XC: begin red_in = z_byte; green_in = x_byte; blue_in = c_byte; end
         SEC_X0C: begin red_in = x_byte; green_in = z_byte; blue_in = c_byte; end
         default: begin red_in = c_byte; green_in = z_byte; blue_in = x_byte; end
      endcase
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         sec1_ff   <= in_item.sector;
         d1_ff     <= in_item.delta;
         v_1_ff    <= in_item.bri;
         chr1_ff   <= chr1_in;
         sec2_ff   <= sec1_ff;
         vfull2_ff <= vfull2_in;
         chr2_ff   <= chr1_ff;
         prod2_ff  <= prod2_in;
         sec3_ff   <= sec2_ff;
         numc3_ff  <= numc3_in;
         numz3_ff  <= numz3_in;
         numx3_ff  <= numx3_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

FILE: src/hsv_to_rgb_converter_top.sv
// HSV to 8-bit RGB pixel converter. Takes one pixel per clock and returns one
// RGB pixel per clock while the result side keeps rsp_tready high; results come
// out in input order (the front register loads at the accepting edge, then come
// queue, three arithmetic stages and output register). The rate is set by the
// back pipeline, which advances whenever its output register is empty or taken.
// Hue is in 1/64 degree, saturation and brightness in 1/4096 (values above
// 1.0 clamp to 1.0, hue of 360 degrees or more uses the last sector).
module hsv_to_rgb_converter_top import hsv2rgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // hue[14:0], saturation[27:15], brightness[40:28], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   logic     f_valid, f_ready;
   item_type f_item;
   logic     q_valid, q_ready;
   item_type q_item;
   logic [7:0] red, green, blue;

   // Front: clamp and sector classification
   hsv2rgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_hue    (req_tdata[HUE_W-1:0]),
      .in_sat    (req_tdata[HUE_W+SV_W-1:HUE_W]),
      .in_bri    (req_tdata[HUE_W+2*SV_W-1:HUE_W+SV_W]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   // Decoupling queue
   hsv2rgb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   // Back: arithmetic and channel mapping
   hsv2rgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_red   (red),
      .out_green (green),
      .out_blue  (blue)
   );

   assign rsp_tdata = {blue, green, red};

endmodule
